// File: rtl/closest_pair_search_assert.svh
// assertion macros for the checker of the closest pair search
`ifndef CLOSEST_PAIR_SEARCH_ASSERT_SVH
`define CLOSEST_PAIR_SEARCH_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int OUT_IDX_W  = 6;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] first_index;
    logic [OUT_IDX_W-1:0] second_index;
    logic [DIST_W-1:0]    distance_squared;
    logic                 pair_valid;
    logic                 points_dropped;
  } out_item_t;

  // one anchor point travelling down the cell row with its running best
  typedef struct packed {
    logic                      vld;
    logic [IDX_W-1:0]          anchor;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic                      found;
    logic [DIST_W-1:0]         best;
    logic [IDX_W-1:0]          best_j;
  } token_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;
    logic signed [COORD_W-1:0] wr_x;
    logic signed [COORD_W-1:0] wr_y;
    logic [CNT_W-1:0]          n;
  } cell_ctl_t;

  function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W+OUT_IDX_W-1:0] ext;
    ext = {{OUT_IDX_W{1'b0}}, v};
    return ext[OUT_IDX_W-1:0];
  endfunction

endpackage

// File: rtl/cps_cell.sv
`timescale 1ns / 1ps

module cps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [cps_pkg::IDX_W-1:0] cell_idx,
  input  cps_pkg::cell_ctl_t ctl,
  input  cps_pkg::token_t   tok_in,
  output cps_pkg::token_t   tok_out
);

  logic signed [cps_pkg::COORD_W-1:0] x_r, y_r;

  cps_pkg::token_t                 s1_tok_r, s1_tok_nxt;
  logic                            s1_act_r, s1_act_nxt;
  logic [cps_pkg::SQ_W-1:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  cps_pkg::token_t                 s2_tok_r, s2_tok_nxt;

  logic signed [cps_pkg::COORD_W:0] dx, dy, adx, ady;
  logic [cps_pkg::COORD_W-1:0]      mx, my;
  logic [cps_pkg::DIST_W-1:0]       sum;

  // point storage, written once per set
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      x_r <= ctl.wr_x;
      y_r <= ctl.wr_y;
    end
  end

  // stage 1: pick up the anchor at its own cell, square the offsets
  always_comb begin
    s1_tok_nxt = tok_in;
    if (tok_in.anchor == cell_idx) begin
      s1_tok_nxt.ax = x_r;
      s1_tok_nxt.ay = y_r;
    end
    s1_act_nxt = tok_in.vld && (cell_idx > tok_in.anchor) &&
                 (cps_pkg::CNT_W'(cell_idx) < ctl.n);
    dx  = {x_r[cps_pkg::COORD_W-1], x_r} - {tok_in.ax[cps_pkg::COORD_W-1], tok_in.ax};
    dy  = {y_r[cps_pkg::COORD_W-1], y_r} - {tok_in.ay[cps_pkg::COORD_W-1], tok_in.ay};
    adx = dx[cps_pkg::COORD_W] ? -dx : dx;
    ady = dy[cps_pkg::COORD_W] ? -dy : dy;
    mx  = adx[cps_pkg::COORD_W-1:0];
    my  = ady[cps_pkg::COORD_W-1:0];
    sqx_nxt = cps_pkg::SQ_W'(mx) * cps_pkg::SQ_W'(mx);
    sqy_nxt = cps_pkg::SQ_W'(my) * cps_pkg::SQ_W'(my);
  end

  // stage 2: add and keep the earliest strict minimum
  always_comb begin
    sum        = cps_pkg::DIST_W'(sqx_r) + cps_pkg::DIST_W'(sqy_r);
    s2_tok_nxt = s1_tok_r;
    if (s1_act_r && (!s1_tok_r.found || (sum < s1_tok_r.best))) begin
      s2_tok_nxt.found  = 1'b1;
      s2_tok_nxt.best   = sum;
      s2_tok_nxt.best_j = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r.vld <= 1'b0;
      s1_act_r     <= 1'b0;
      s2_tok_r.vld <= 1'b0;
    end else begin
      s1_tok_r <= s1_tok_nxt;
      s1_act_r <= s1_act_nxt;
      s2_tok_r <= s2_tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
  end

  assign tok_out = s2_tok_r;

endmodule

// File: rtl/closest_pair_search.sv
`timescale 1ns / 1ps

// Brute-force closest pair search over up to cps_pkg::MAX_POINTS signed 16-bit 2D points.
// A transaction on the input (start high while busy is low) loads one point, one cycle
// per point; busy stays low while loading. The point flagged last_point ends the set.
// With fewer than two points held the result strobes on out_valid in the next cycle
// with pair_valid low. Otherwise busy rises for a search over the n points held, and
// the result strobes on out_valid in the cycle busy falls. The search runs along the
// row of cells: one anchor point enters the row per cycle and each cell spends two
// register stages on it (square, then add and compare). The result is shown for one
// cycle only and the receiver cannot hold it off, so it must be captured when out_valid
// is high. Ties go to the earliest pair (lowest first index, then lowest second index).
// Points beyond capacity are dropped and reported through points_dropped; a dropped last
// point still starts the search.

module closest_pair_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cps_pkg::in_item_t  in_data,
  output logic               out_valid,
  output cps_pkg::out_item_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [cps_pkg::CNT_W-1:0]  count_r, count_nxt;   // points held in this set
  logic                       ovf_r, ovf_nxt;       // a point found the store full
  logic [cps_pkg::CNT_W-1:0]  n_r, n_nxt;           // set size frozen for the search
  logic                       drop_r, drop_nxt;
  logic [cps_pkg::IDX_W-1:0]  inj_r, inj_nxt;       // next anchor to launch
  logic                       inj_done_r, inj_done_nxt;
  logic                       gfound_r, gfound_nxt; // best over finished anchors
  logic [cps_pkg::DIST_W-1:0] gbest_r, gbest_nxt;
  logic [cps_pkg::IDX_W-1:0]  gi_r, gi_nxt, gj_r, gj_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cps_pkg::out_item_t         out_data_r, out_data_nxt;

  cps_pkg::cell_ctl_t         ctl;
  cps_pkg::token_t            tok [cps_pkg::MAX_POINTS+1];

  logic                       accept;
  logic                       has_room;
  logic [cps_pkg::CNT_W-1:0]  cnt_after;
  logic                       ovf_after;
  logic [cps_pkg::CNT_W-1:0]  n_m2;
  logic [cps_pkg::IDX_W-1:0]  last_anchor;
  logic                       take;
  logic [cps_pkg::DIST_W-1:0] cand_best;
  logic [cps_pkg::IDX_W-1:0]  cand_i, cand_j;

  assign busy      = (state_r == S_SEARCH);
  assign accept    = start && (state_r == S_IDLE);
  assign has_room  = (count_r < cps_pkg::CNT_W'(cps_pkg::MAX_POINTS));
  assign cnt_after = has_room ? (count_r + cps_pkg::CNT_W'(1)) : count_r;
  assign ovf_after = ovf_r | ~has_room;

  // anchors run from 0 to n-2; the last one closes the search
  assign n_m2        = n_r - cps_pkg::CNT_W'(2);
  assign last_anchor = n_m2[cps_pkg::IDX_W-1:0];

  // tokens leave the row in anchor order, so a strict compare keeps the earliest pair
  assign take      = tok[cps_pkg::MAX_POINTS].vld && tok[cps_pkg::MAX_POINTS].found &&
                     (!gfound_r || (tok[cps_pkg::MAX_POINTS].best < gbest_r));
  assign cand_best = take ? tok[cps_pkg::MAX_POINTS].best   : gbest_r;
  assign cand_i    = take ? tok[cps_pkg::MAX_POINTS].anchor : gi_r;
  assign cand_j    = take ? tok[cps_pkg::MAX_POINTS].best_j : gj_r;

  // the row of cells, one point per cell
  for (genvar k = 0; k < cps_pkg::MAX_POINTS; k++) begin : g_cell
    cps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (cps_pkg::IDX_W'(k)),
      .ctl      (ctl),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    drop_nxt      = drop_r;
    inj_nxt       = inj_r;
    inj_done_nxt  = inj_done_r;
    gfound_nxt    = gfound_r;
    gbest_nxt     = gbest_r;
    gi_nxt        = gi_r;
    gj_nxt        = gj_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    ctl.wr_en  = 1'b0;
    ctl.wr_idx = count_r[cps_pkg::IDX_W-1:0];
    ctl.wr_x   = in_data.coord_x;
    ctl.wr_y   = in_data.coord_y;
    ctl.n      = n_r;

    tok[0]        = '0;
    tok[0].anchor = inj_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // store the point if there is room, else just remember the drop
          ctl.wr_en = has_room;
          count_nxt = cnt_after;
          ovf_nxt   = ovf_after;
          if (in_data.last_point) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            if (cnt_after >= cps_pkg::CNT_W'(2)) begin
              state_nxt    = S_SEARCH;
              n_nxt        = cnt_after;
              drop_nxt     = ovf_after;
              inj_nxt      = '0;
              inj_done_nxt = 1'b0;
              gfound_nxt   = 1'b0;
            end else begin
              // too few points: answer at once
              out_valid_nxt                 = 1'b1;
              out_data_nxt.first_index      = '0;
              out_data_nxt.second_index     = '0;
              out_data_nxt.distance_squared = '0;
              out_data_nxt.pair_valid       = 1'b0;
              out_data_nxt.points_dropped   = ovf_after;
            end
          end
        end
      end
      S_SEARCH: begin
        // launch one anchor per cycle
        tok[0].vld = !inj_done_r;
        if (!inj_done_r) begin
          if (inj_r == last_anchor) begin
            inj_done_nxt = 1'b1;
          end else begin
            inj_nxt = inj_r + cps_pkg::IDX_W'(1);
          end
        end
        // fold each finished anchor into the overall best
        if (tok[cps_pkg::MAX_POINTS].vld) begin
          gfound_nxt = gfound_r | take;
          gbest_nxt  = cand_best;
          gi_nxt     = cand_i;
          gj_nxt     = cand_j;
          if (tok[cps_pkg::MAX_POINTS].anchor == last_anchor) begin
            state_nxt                     = S_IDLE;
            out_valid_nxt                 = 1'b1;
            out_data_nxt.first_index      = cps_pkg::out_idx(cand_i);
            out_data_nxt.second_index     = cps_pkg::out_idx(cand_j);
            out_data_nxt.distance_squared = cand_best;
            out_data_nxt.pair_valid       = 1'b1;
            out_data_nxt.points_dropped   = drop_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      inj_done_r  <= 1'b1;
      gfound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      drop_r      <= drop_nxt;
      inj_r       <= inj_nxt;
      inj_done_r  <= inj_done_nxt;
      gfound_r    <= gfound_nxt;
      gbest_r     <= gbest_nxt;
      gi_r        <= gi_nxt;
      gj_r        <= gj_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/cps_checker.sv
`timescale 1ns / 1ps

`include "closest_pair_search_assert.svh"

module cps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input cps_pkg::in_item_t  in_data,
  input logic               out_valid,
  input cps_pkg::out_item_t out_data
);

  logic last_in;
  logic zero_pair;

  // last point of a set taken in this cycle
  assign last_in   = start && !busy && in_data.last_point;
  assign zero_pair = (out_data.first_index == '0) && (out_data.second_index == '0) &&
                     (out_data.distance_squared == '0);

  // a set that ends always produces a result or starts a search
  `CPS_ASSERT_NEXT(a_last_answered, clk, rst_n, last_in, out_valid || busy)

  // a finished search always shows its result as busy drops
  `CPS_ASSERT_NOW(a_done_strobe, clk, rst_n, $fell(busy), out_valid)

  // entering a search never coincides with a result transaction
  `CPS_ASSERT_NOW(a_start_quiet, clk, rst_n, $rose(busy), !out_valid)

  // an empty or single point set reports a zeroed pair
  `CPS_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !out_data.pair_valid, zero_pair)

endmodule

bind closest_pair_search cps_checker u_cps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // cycles without any transaction before the run is declared hung
  // (the limit exceeds the longest search plus the longest sender gap)
  localparam int HANG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 3 * cps_pkg::MAX_POINTS + 20;
  localparam int ITEM_TARGET = 1950;

  // coordinate flavors for generated sets
  typedef enum int {
    COORD_FULL,
    COORD_CLUSTER,
    COORD_EXTREME
  } coord_style_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  cps_pkg::in_item_t  in_data   = '0;
  logic               busy;
  logic               out_valid;
  cps_pkg::out_item_t out_data;

  // stimulus and prediction state
  cps_pkg::in_item_t  pending_points[$];
  cps_pkg::out_item_t closest_expected[$];
  logic signed [cps_pkg::COORD_W-1:0] held_x [cps_pkg::MAX_POINTS];
  logic signed [cps_pkg::COORD_W-1:0] held_y [cps_pkg::MAX_POINTS];
  logic [cps_pkg::CNT_W-1:0] held_count    = '0;
  logic                      held_overflow = 1'b0;

  int mismatch_count = 0;
  int gap_left       = 0;
  int idle_cycles    = 0;
  int queued_items   = 0;
  bit no_gap_stretch = 1'b0;

  closest_pair_search u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // exact squared distance between two held points
  function automatic longint sq_dist(input int a, input int b);
    longint dx, dy;
    dx = longint'(held_x[b]) - longint'(held_x[a]);
    dy = longint'(held_y[b]) - longint'(held_y[a]);
    return dx * dx + dy * dy;
  endfunction

  // store one accepted point; on the last point of a set, search all pairs
  task automatic take_point(input cps_pkg::in_item_t item);
    cps_pkg::out_item_t res;
    longint             best, d;
    int                 bi, bj;
    if (held_count < cps_pkg::MAX_POINTS) begin
      held_x[held_count] = item.coord_x;
      held_y[held_count] = item.coord_y;
      held_count++;
    end else begin
      // store full: the point is lost, but a last point still triggers the search
      held_overflow = 1'b1;
    end
    if (item.last_point) begin
      res = '0;
      if (held_count >= 2) begin
        bi   = 0;
        bj   = 1;
        best = sq_dist(0, 1);
        // strict less-than keeps the earliest pair on ties
        for (int i = 0; i < held_count; i++) begin
          for (int j = i + 1; j < held_count; j++) begin
            d = sq_dist(i, j);
            if (d < best) begin
              best = d;
              bi   = i;
              bj   = j;
            end
          end
        end
        res.first_index      = bi[cps_pkg::OUT_IDX_W-1:0];
        res.second_index     = bj[cps_pkg::OUT_IDX_W-1:0];
        res.distance_squared = best[cps_pkg::DIST_W-1:0];
        res.pair_valid       = 1'b1;
      end
      res.points_dropped = held_overflow;
      closest_expected.push_back(res);
      held_count    = '0;
      held_overflow = 1'b0;
    end
  endtask

  // sender gap: mostly none or short, a few long, with stretches of back-to-back items
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 149) == 0) no_gap_stretch = !no_gap_stretch;
    if (no_gap_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_point(input int x, input int y, input bit last);
    cps_pkg::in_item_t item;
    item.coord_x    = x[cps_pkg::COORD_W-1:0];
    item.coord_y    = y[cps_pkg::COORD_W-1:0];
    item.last_point = last;
    pending_points.push_back(item);
    queued_items++;
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // one set of n points with coordinates of the chosen flavor
  task automatic queue_set(input int n, input coord_style_t style);
    int bx, by, x, y;
    bx = $urandom_range(0, 65535) - 32768;
    by = $urandom_range(0, 65535) - 32768;
    for (int k = 0; k < n; k++) begin
      case (style)
        COORD_FULL: begin
          x = $urandom_range(0, 65535) - 32768;
          y = $urandom_range(0, 65535) - 32768;
        end
        COORD_CLUSTER: begin
          // tiny offsets make equal distances, and so ties, common
          x = bx + $urandom_range(0, 3);
          y = by + $urandom_range(0, 3);
        end
        default: begin
          x = extreme_coord();
          y = extreme_coord();
        end
      endcase
      queue_point(x, y, k == n - 1);
    end
  endtask

  // driver: presents pending points, one transaction per start high with busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else if (!(start && busy)) begin
      if (start) take_point(in_data);
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_points.size() != 0) begin
        start    <= 1'b1;
        in_data  <= pending_points.pop_front();
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobed result is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    cps_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (closest_expected.size() == 0) begin
        report_mismatch("unexpected result, distance_squared", out_data.distance_squared, 0);
      end else begin
        want = closest_expected.pop_front();
        if (out_data.first_index !== want.first_index)
          report_mismatch("first_index", out_data.first_index, want.first_index);
        if (out_data.second_index !== want.second_index)
          report_mismatch("second_index", out_data.second_index, want.second_index);
        if (out_data.distance_squared !== want.distance_squared)
          report_mismatch("distance_squared", out_data.distance_squared,
                          want.distance_squared);
        if (out_data.pair_valid !== want.pair_valid)
          report_mismatch("pair_valid", out_data.pair_valid, want.pair_valid);
        if (out_data.points_dropped !== want.points_dropped)
          report_mismatch("points_dropped", out_data.points_dropped, want.points_dropped);
      end
    end
  end

  // watchdog: no transaction on either side for too long means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    // directed sets
    // single point: no pair to report
    queue_point(-32768, 32767, 1'b1);
    // opposite corners: the largest distance there is
    queue_point(-32768, -32768, 1'b0);
    queue_point(32767, 32767, 1'b1);
    queue_point(32767, -32768, 1'b0);
    queue_point(-32768, 32767, 1'b1);
    // coincident points: zero distance
    queue_point(5, 5, 1'b0);
    queue_point(5, 5, 1'b1);
    // equal distances on a line: earliest pair wins
    queue_point(0, 0, 1'b0);
    queue_point(1, 0, 1'b0);
    queue_point(2, 0, 1'b1);
    // closest pair is the last one checked
    queue_point(-1000, 0, 1'b0);
    queue_point(1000, 0, 1'b0);
    queue_point(0, 500, 1'b0);
    queue_point(3, 501, 1'b1);
    // later pair ties the first pair: first pair kept
    queue_point(0, 0, 1'b0);
    queue_point(10, 0, 1'b0);
    queue_point(100, 100, 1'b0);
    queue_point(100, 110, 1'b1);
    // neighbors at the negative edge
    queue_point(-32768, 0, 1'b0);
    queue_point(-32767, 0, 1'b1);

    // random sets: mostly small, some medium, a few around and past capacity
    while (queued_items < ITEM_TARGET) begin : random_sets
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 93) n = $urandom_range(9, 24);
      else n = $urandom_range(cps_pkg::MAX_POINTS - 4, cps_pkg::MAX_POINTS + 6);
      queue_set(n, coord_style_t'($urandom_range(0, 2)));
    end

    // reset, once
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // all points handed over, then all results in, then a quiet tail
    while (pending_points.size() != 0 || start) @(posedge clk);
    while (closest_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cps_pkg.sv
rtl/cps_cell.sv
rtl/closest_pair_search.sv
rtl/cps_checker.sv
bench/testbench.sv
